FILE: design/triangle_normal_point_inside_test_macros.svh
// Assertion macros used by the checker file
`ifndef TRIANGLE_NORMAL_POINT_INSIDE_TEST_MACROS_SVH
`define TRIANGLE_NORMAL_POINT_INSIDE_TEST_MACROS_SVH

// Checked only while out of reset
`define TNPI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define TNPI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tnpi_pkg.sv
// Types, widths and control structs for the triangle normal / inside test
`default_nettype none
package tnpi_pkg;
	localparam int COORD_W   = 16;
	localparam int NORM_FRAC = 14;
	localparam int NORM_W    = 16;
	localparam int THR_W     = 32;

	localparam int EW   = COORD_W + 1;      // edge / relative vector
	localparam int PW   = 2 * EW;           // one cross product term
	localparam int CW   = PW + 1;           // cross product component
	localparam int CMW  = CW - 1;           // its magnitude
	localparam int C2W  = 2 * CMW;          // squared component
	localparam int SW   = C2W + 2;          // squared length
	localparam int DPW  = 2 * CW;           // dot product term
	localparam int DW   = DPW + 2;          // dot product
	localparam int QW   = 2 * NORM_FRAC + 3; // scaled ratio c^2 * 4^(F+1) / S
	localparam int MW   = NORM_FRAC + 1;    // rounded normal magnitude
	localparam int OW   = NORM_FRAC + 2;    // odd candidate 2m-1
	localparam int OSW  = 2 * OW;           // its square
	localparam int GEOM_STAGES = 5;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert0_x;
		logic signed [COORD_W-1:0] vert0_y;
		logic signed [COORD_W-1:0] vert0_z;
		logic signed [COORD_W-1:0] vert1_x;
		logic signed [COORD_W-1:0] vert1_y;
		logic signed [COORD_W-1:0] vert1_z;
		logic signed [COORD_W-1:0] vert2_x;
		logic signed [COORD_W-1:0] vert2_y;
		logic signed [COORD_W-1:0] vert2_z;
		logic signed [COORD_W-1:0] query_x;
		logic signed [COORD_W-1:0] query_y;
		logic signed [COORD_W-1:0] query_z;
	} tnpi_in_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     inside_res;
		logic                     degenerate;
	} tnpi_out_t;

	// geometry front end to divider
	typedef struct packed {
		logic                     valid;
		logic                     degen;
		logic                     in_tri;
		logic [2:0]               neg;
		logic [SW-1:0]            s;
		logic [2:0][C2W-1:0]      c2;
	} tnpi_geo_t;

	// divider to rounding stages
	typedef struct packed {
		logic                     valid;
		logic                     degen;
		logic                     in_tri;
		logic [2:0]               neg;
		logic [2:0][QW-1:0]       q;
	} tnpi_quo_t;
endpackage
`default_nettype wire

FILE: design/tnpi_geom.sv
// Edge vectors, cross and dot products, squared length and inside test
`default_nettype none
module tnpi_geom import tnpi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire tnpi_in_t         in_data,
	input  wire logic [THR_W-1:0] thr,
	output tnpi_geo_t             geo
);
	logic signed [COORD_W-1:0] crd [4][3];
	logic signed [EW-1:0] edge_s1 [3][3];
	logic signed [EW-1:0] rel_s1 [3][3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] va [4][3];
	logic signed [EW-1:0] vb [4][3];
	logic signed [PW-1:0] prod_s2 [4][6];
	logic signed [CW-1:0] cross_s3 [4][3];
	logic [CMW-1:0] cmag [3];
	logic [C2W-1:0] sq_s4 [3];
	logic signed [DPW-1:0] dp_s4 [3][3];
	logic [2:0] neg_s4, neg_s5;
	logic [SW-1:0] s_sum;
	logic signed [DW-1:0] dsum [3];
	logic any_neg, any_pos;
	logic [SW-1:0] s_s5;
	logic [C2W-1:0] c2_s5 [3];
	logic degen_s5, inside_s5;
	logic [GEOM_STAGES:1] vld_s;

	always_comb begin
		crd[0][0] = in_data.vert0_x; crd[0][1] = in_data.vert0_y; crd[0][2] = in_data.vert0_z;
		crd[1][0] = in_data.vert1_x; crd[1][1] = in_data.vert1_y; crd[1][2] = in_data.vert1_z;
		crd[2][0] = in_data.vert2_x; crd[2][1] = in_data.vert2_y; crd[2][2] = in_data.vert2_z;
		crd[3][0] = in_data.query_x; crd[3][1] = in_data.query_y; crd[3][2] = in_data.query_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[GEOM_STAGES-1:1], in_valid};
		end
	end

	// stage 1: edges V(k+1)-Vk, P-Vk, and V2-V0
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					edge_s1[k][i] <= EW'(crd[(k + 1) % 3][i]) - EW'(crd[k][i]);
					rel_s1[k][i]  <= EW'(crd[3][i]) - EW'(crd[k][i]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				e2_s1[i] <= EW'(crd[2][i]) - EW'(crd[0][i]);
			end
		end
	end

	// set 0 is the face normal, sets 1..3 the edge crosses
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[0][i] = edge_s1[0][i];
			vb[0][i] = e2_s1[i];
			for (int k = 0; k < 3; k++) begin
				va[k + 1][i] = rel_s1[k][i];
				vb[k + 1][i] = edge_s1[k][i];
			end
		end
	end

	// stage 2: cross product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				prod_s2[n][0] <= PW'(va[n][1]) * PW'(vb[n][2]);
				prod_s2[n][1] <= PW'(va[n][2]) * PW'(vb[n][1]);
				prod_s2[n][2] <= PW'(va[n][2]) * PW'(vb[n][0]);
				prod_s2[n][3] <= PW'(va[n][0]) * PW'(vb[n][2]);
				prod_s2[n][4] <= PW'(va[n][0]) * PW'(vb[n][1]);
				prod_s2[n][5] <= PW'(va[n][1]) * PW'(vb[n][0]);
			end
		end
	end

	// stage 3: cross product components
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 4; n++) begin
				for (int i = 0; i < 3; i++) begin
					cross_s3[n][i] <= CW'(prod_s2[n][2 * i]) - CW'(prod_s2[n][2 * i + 1]);
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmag[i] = cross_s3[0][i][CW-1] ? CMW'(-cross_s3[0][i]) : CMW'(cross_s3[0][i]);
		end
	end

	// stage 4: squares of the normal and dot product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i]  <= C2W'(cmag[i]) * C2W'(cmag[i]);
				neg_s4[i] <= cross_s3[0][i][CW-1];
				for (int k = 0; k < 3; k++) begin
					dp_s4[k][i] <= DPW'(cross_s3[k + 1][i]) * DPW'(cross_s3[0][i]);
				end
			end
		end
	end

	always_comb begin
		s_sum = SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
		any_neg = 1'b0;
		any_pos = 1'b0;
		for (int k = 0; k < 3; k++) begin
			dsum[k] = DW'(dp_s4[k][0]) + DW'(dp_s4[k][1]) + DW'(dp_s4[k][2]);
			if (dsum[k][DW-1]) begin
				any_neg = 1'b1;
			end else if (dsum[k] != '0) begin
				any_pos = 1'b1;
			end
		end
	end

	// stage 5: squared length, threshold and sign agreement
	always_ff @(posedge clk) begin
		if (en) begin
			s_s5      <= s_sum;
			degen_s5  <= (s_sum <= SW'(thr));
			inside_s5 <= (s_sum <= SW'(thr)) || !any_neg || !any_pos;
			neg_s5    <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				c2_s5[i] <= sq_s4[i];
			end
		end
	end

	always_comb begin
		geo.valid  = vld_s[GEOM_STAGES];
		geo.degen  = degen_s5;
		geo.in_tri = inside_s5;
		geo.neg    = neg_s5;
		geo.s      = s_s5;
		for (int i = 0; i < 3; i++) begin
			geo.c2[i] = c2_s5[i];
		end
	end
endmodule
`default_nettype wire

FILE: design/tnpi_div.sv
// Restoring divider, one quotient bit per stage: q = c^2 * 4^(F+1) / S
`default_nettype none
module tnpi_div import tnpi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire tnpi_geo_t geo,
	output tnpi_quo_t      quo
);
	logic [SW-1:0] rem_s [QW][3];
	logic [QW-1:0] q_s [QW][3];
	logic [SW-1:0] s_s [QW];
	logic [QW-1:0] vld_s;
	logic [QW-1:0] degen_s, inside_s;
	logic [2:0] neg_s [QW];

	for (genvar j = 0; j < QW; j++) begin : g_st
		logic [SW-1:0] rem_i [3];
		logic [QW-1:0] q_i [3];
		logic [SW-1:0] s_i;
		logic          b_i [3];
		logic          vld_i, degen_i, inside_i;
		logic [2:0]    neg_i;
		logic [SW:0]   sh [3];
		logic          ge [3];

		if (j == 0) begin : g_first
			// remainder starts at c^2 / 2; c^2[0] is the only nonzero bit left
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_i[i] = SW'(geo.c2[i] >> 1);
					q_i[i]   = '0;
					b_i[i]   = geo.c2[i][0];
				end
				s_i      = geo.s;
				vld_i    = geo.valid;
				degen_i  = geo.degen;
				inside_i = geo.in_tri;
				neg_i    = geo.neg;
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_i[i] = rem_s[j - 1][i];
					q_i[i]   = q_s[j - 1][i];
					b_i[i]   = 1'b0;
				end
				s_i      = s_s[j - 1];
				vld_i    = vld_s[j - 1];
				degen_i  = degen_s[j - 1];
				inside_i = inside_s[j - 1];
				neg_i    = neg_s[j - 1];
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sh[i] = {rem_i[i], b_i[i]};
				ge[i] = (sh[i] >= {1'b0, s_i});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j][i] <= ge[i] ? SW'(sh[i] - {1'b0, s_i}) : SW'(sh[i]);
					q_s[j][i]   <= {q_i[i][QW-2:0], ge[i]};
				end
				s_s[j]      <= s_i;
				degen_s[j]  <= degen_i;
				inside_s[j] <= inside_i;
				neg_s[j]    <= neg_i;
			end
		end
	end

	always_comb begin
		quo.valid  = vld_s[QW-1];
		quo.degen  = degen_s[QW-1];
		quo.in_tri = inside_s[QW-1];
		quo.neg    = neg_s[QW-1];
		for (int i = 0; i < 3; i++) begin
			quo.q[i] = q_s[QW-1][i];
		end
	end
endmodule
`default_nettype wire

FILE: design/tnpi_round.sv
// Rounded normal: largest m <= 2^F with (2m-1)^2 <= q, one bit per stage
`default_nettype none
module tnpi_round import tnpi_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire tnpi_quo_t quo,
	output logic           out_valid,
	output tnpi_out_t      out_data
);
	localparam int RS = NORM_FRAC + 1;
	localparam logic [MW-1:0] ONE = MW'(1) << NORM_FRAC;

	logic [MW-1:0] m_s [RS][3];
	logic [QW-1:0] q_s [RS][3];
	logic [RS-1:0] vld_s, degen_s, inside_s;
	logic [2:0] neg_s [RS];
	logic [MW:0] sv [3];
	logic signed [NORM_W-1:0] nv [3];
	logic vld_q;
	tnpi_out_t out_q;

	for (genvar j = 0; j < RS; j++) begin : g_st
		logic [MW-1:0]  m_i [3];
		logic [QW-1:0]  q_i [3];
		logic           vld_i, degen_i, inside_i;
		logic [2:0]     neg_i;
		logic [MW-1:0]  t [3];
		logic [OW-1:0]  odd [3];
		logic [OSW-1:0] osq [3];
		logic           take [3];

		if (j == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					m_i[i] = '0;
					q_i[i] = quo.q[i];
				end
				vld_i    = quo.valid;
				degen_i  = quo.degen;
				inside_i = quo.in_tri;
				neg_i    = quo.neg;
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					m_i[i] = m_s[j - 1][i];
					q_i[i] = q_s[j - 1][i];
				end
				vld_i    = vld_s[j - 1];
				degen_i  = degen_s[j - 1];
				inside_i = inside_s[j - 1];
				neg_i    = neg_s[j - 1];
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]    = m_i[i] | (MW'(1) << (NORM_FRAC - j));
				odd[i]  = {t[i], 1'b0} - OW'(1);
				osq[i]  = OSW'(odd[i]) * OSW'(odd[i]);
				take[i] = (t[i] <= ONE) && (osq[i] <= OSW'(q_i[i]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					m_s[j][i] <= take[i] ? t[i] : m_i[i];
					q_s[j][i] <= q_i[i];
				end
				degen_s[j]  <= degen_i;
				inside_s[j] <= inside_i;
				neg_s[j]    <= neg_i;
			end
		end
	end

	// apply sign, zero on degenerate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sv[i] = neg_s[RS-1][i] ? -{1'b0, m_s[RS-1][i]} : {1'b0, m_s[RS-1][i]};
			nv[i] = degen_s[RS-1] ? '0 : NORM_W'($signed(sv[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[RS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.normal_x   <= nv[0];
			out_q.normal_y   <= nv[1];
			out_q.normal_z   <= nv[2];
			out_q.inside_res <= inside_s[RS-1];
			out_q.degenerate <= degen_s[RS-1];
		end
	end

	assign out_valid = vld_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

FILE: design/triangle_normal_point_inside_test.sv
// Top level: triangle face normal and same-side point-in-triangle test
//
//  channel | signals                      | dir | item
//  --------+------------------------------+-----+---------------------------
//  in      | in_valid, in_stall, in_data  | in  | three vertices, query point
//  out     | out_valid, out_stall,out_data| out | unit normal, inside, degen
//  cfg     | cfg_we, cfg_wdata            | in  | degenerate_threshold
//
//  One item per cycle while the output is not stalled; an item passes
//  the geometry stages, one divider stage per quotient bit, one rounding
//  stage per normal bit and the output register. A stalled output freezes
//  every stage. Reset clears all valid bits; the threshold resets to 1.
`default_nettype none
module triangle_normal_point_inside_test import tnpi_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire tnpi_in_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output tnpi_out_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [THR_W-1:0] cfg_wdata
);
	logic [THR_W-1:0] thr_q;
	logic en;
	tnpi_geo_t geo;
	tnpi_quo_t quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// hold the whole pipe while the result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	tnpi_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_data  (in_data),
		.thr      (thr_q),
		.geo      (geo)
	);

	tnpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.geo    (geo),
		.quo    (quo)
	);

	tnpi_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.quo       (quo),
		.out_valid (out_valid),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire

FILE: design/tnpi_checker.sv
// Port-level checks for the triangle normal / inside test, bound to the top
`default_nettype none
`include "triangle_normal_point_inside_test_macros.svh"
module tnpi_checker import tnpi_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire tnpi_out_t out_data
);
	logic held, degen_ok, norm_ok;

	assign held = out_valid && out_stall;

	assign degen_ok = out_data.normal_x == '0 && out_data.normal_y == '0 &&
		out_data.normal_z == '0 && out_data.inside_res;

	assign norm_ok = out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
		out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384 &&
		out_data.normal_z <= 16'sd16384 && out_data.normal_z >= -16'sd16384;

	`TNPI_ASSERT_ALWAYS(a_rst_empty, (!arst_n |-> !out_valid), "output valid during reset")
	`TNPI_ASSERT(a_stall_cause, (in_stall |-> held), "input stall without output stall")
	`TNPI_ASSERT(a_degen_zero, ((out_valid && out_data.degenerate) |-> degen_ok), "bad degen item")
	`TNPI_ASSERT(a_norm_range, (out_valid |-> norm_ok), "normal component out of range")
	`TNPI_ASSERT(a_out_hold, (held |=> (out_valid && $stable(out_data))), "stalled item changed")
endmodule

bind triangle_normal_point_inside_test tnpi_checker u_tnpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire
